// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the entity unescaper RTL.
// Each macro expects clk_i and the active-low reset rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define XEU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define XEU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/xeu_pkg.sv =====
// Shared types, constants and helper functions of the XML entity unescaper.
// No dependencies.
`timescale 1ns / 1ps

package xeu_pkg;

  localparam int unsigned MAX_ENTITY_LEN_DEF = 16;
  localparam int unsigned CP_W = 21;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NUM_NAMES = 5;
  localparam logic [CP_W-1:0] MAX_CODE_POINT = 21'h10FFFF;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNTERM  = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_BADNUM  = 3'd3,
    ST_TOOLONG = 3'd4
  } status_e;

  // One group of result words caused by a single input word.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nm1;
    logic            last;
    status_e         status;
  } grp_t;

  // Named entities, in order: lt, gt, amp, quot, apos.
  function automatic logic [7:0] ent_char(input logic [2:0] which, input logic [1:0] pos);
    logic [31:0] word;
    case (which)
      3'd0: word = 32'h0000_746c;
      3'd1: word = 32'h0000_7467;
      3'd2: word = 32'h0070_6d61;
      3'd3: word = 32'h746f_7571;
      3'd4: word = 32'h736f_7061;
      default: word = 32'h0;
    endcase
    return word[8*pos +: 8];
  endfunction

  function automatic logic [2:0] name_len(input logic [2:0] which);
    logic [2:0] len;
    case (which)
      3'd0, 3'd1: len = 3'd2;
      3'd2: len = 3'd3;
      3'd3, 3'd4: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_repl(input logic [2:0] which);
    logic [7:0] c;
    case (which)
      3'd0: c = 8'h3C;
      3'd1: c = 8'h3E;
      3'd2: c = 8'h26;
      3'd3: c = 8'h22;
      3'd4: c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns the valid flag in bit 4 and the digit value in bits 3:0.
  function automatic logic [4:0] digit_val(input logic [7:0] b, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (hex && b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (hex && b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic grp_t utf8_encode(input logic [CP_W-1:0] cp);
    grp_t g;
    g = '0;
    g.status = ST_OK;
    if (cp < 21'h80) begin
      g.bytes[0] = cp[7:0];
      g.nm1 = 2'd0;
    end else if (cp < 21'h800) begin
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
      g.nm1 = 2'd1;
    end else if (cp < 21'h10000) begin
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
      g.nm1 = 2'd2;
    end else begin
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
      g.nm1 = 2'd3;
    end
    return g;
  endfunction

endpackage

// ===== rtl/core/xeu_decode.sv =====
// Entity decoder: keeps the reference parse state and turns one input word
// into a group of result words. Depends on xeu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xeu_decode #(
  parameter int unsigned MAX_LEN = xeu_pkg::MAX_ENTITY_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          grp_valid_o,
  output xeu_pkg::grp_t grp_o
);
  import xeu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  logic                 in_ref_q, in_ref_d;
  logic                 drop_q, drop_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [NUM_NAMES-1:0] match_q, match_d;
  logic                 hash_q, hash_d;
  logic                 hex_q, hex_d;
  logic                 stop_q, stop_d;
  logic                 anydig_q, anydig_d;
  logic                 big_q, big_d;
  logic [CP_W-1:0]      val_q, val_d;

  logic [4:0]      dig;
  logic [CP_W+3:0] nv;
  logic [2:0]      hit;
  logic            named;
  grp_t            enc;

  assign dig = digit_val(byte_i, hex_q);
  assign nv  = hex_q ? ({val_q, 4'b0} + (CP_W + 4)'(dig[3:0]))
                     : ((CP_W + 4)'({val_q, 3'b0}) + (CP_W + 4)'({val_q, 1'b0})
                        + (CP_W + 4)'(dig[3:0]));
  assign enc = utf8_encode(val_q);

  always_comb begin
    named = 1'b0;
    hit   = 3'd0;
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      if (match_q[k] && cnt_q == CW'(name_len(3'(k)))) begin
        named = 1'b1;
        hit   = 3'(k);
      end
    end
  end

  always_comb begin
    in_ref_d    = in_ref_q;
    drop_d      = drop_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    hash_d      = hash_q;
    hex_d       = hex_q;
    stop_d      = stop_q;
    anydig_d    = anydig_q;
    big_d       = big_q;
    val_d       = val_q;
    grp_valid_o = 1'b0;
    grp_o       = '0;
    grp_o.last  = last_i;
    grp_o.status = ST_OK;

    if (drop_q) begin
      if (last_i) begin
        drop_d = 1'b0;
      end
    end else if (!in_ref_q) begin
      if (byte_i == CH_AMP) begin
        in_ref_d = 1'b1;
        cnt_d    = '0;
        match_d  = '1;
        hash_d   = 1'b0;
        hex_d    = 1'b0;
        stop_d   = 1'b0;
        anydig_d = 1'b0;
        big_d    = 1'b0;
        val_d    = '0;
        if (last_i) begin
          in_ref_d     = 1'b0;
          grp_valid_o  = 1'b1;
          grp_o.status = ST_UNTERM;
        end
      end else begin
        grp_valid_o    = 1'b1;
        grp_o.bytes[0] = byte_i;
      end
    end else if (byte_i == CH_SEMI) begin
      in_ref_d    = 1'b0;
      cnt_d       = '0;
      grp_valid_o = 1'b1;
      if (named) begin
        grp_o.bytes[0] = name_repl(hit);
      end else if (cnt_q > CW'(1) && hash_q) begin
        if (!anydig_q || big_q) begin
          grp_o.status = ST_BADNUM;
          grp_o.last   = 1'b1;
          drop_d       = !last_i;
        end else begin
          grp_o.bytes = enc.bytes;
          grp_o.nm1   = enc.nm1;
        end
      end else begin
        grp_o.status = ST_UNKNOWN;
        grp_o.last   = 1'b1;
        drop_d       = !last_i;
      end
    end else if (cnt_q >= MAX_CNT) begin
      in_ref_d     = 1'b0;
      cnt_d        = '0;
      drop_d       = !last_i;
      grp_valid_o  = 1'b1;
      grp_o.status = ST_TOOLONG;
      grp_o.last   = 1'b1;
    end else begin
      cnt_d = cnt_q + CW'(1);
      for (int k = 0; k < NUM_NAMES; k++) begin
        match_d[k] = match_q[k] && (cnt_q < CW'(name_len(3'(k))))
                     && (byte_i == ent_char(3'(k), cnt_q[1:0]));
      end
      if (cnt_q == '0) begin
        hash_d = (byte_i == CH_HASH);
      end else if (cnt_q == CW'(1) && (byte_i == CH_LX || byte_i == CH_UX)) begin
        hex_d = 1'b1;
      end else if (!stop_q) begin
        if (dig[4]) begin
          anydig_d = 1'b1;
          if (!big_q) begin
            if (nv > (CP_W + 4)'(MAX_CODE_POINT)) begin
              big_d = 1'b1;
            end else begin
              val_d = nv[CP_W-1:0];
            end
          end
        end else begin
          stop_d = 1'b1;
        end
      end
      if (last_i) begin
        in_ref_d     = 1'b0;
        cnt_d        = '0;
        grp_valid_o  = 1'b1;
        grp_o.status = ST_UNTERM;
      end
    end

    if (!step_i) begin
      grp_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ref_q <= 1'b0;
      drop_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (step_i) begin
      in_ref_q <= in_ref_d;
      drop_q   <= drop_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      match_q  <= match_d;
      hash_q   <= hash_d;
      hex_q    <= hex_d;
      stop_q   <= stop_d;
      anydig_q <= anydig_d;
      big_q    <= big_d;
      val_q    <= val_d;
    end
  end

  `XEU_ASSERT(a_cnt_bound, cnt_q <= MAX_CNT, "Name count ran past the entity limit.")
  `XEU_ASSERT(a_ref_drop_excl, !(in_ref_q && drop_q), "Dropping while inside a reference.")
  `XEU_ASSERT_IMP(a_cnt_idle, !in_ref_q, cnt_q == '0, "Name count left set outside a reference.")

endmodule

// ===== rtl/core/xml_entity_unescaper.sv =====
// Top level: input register, xeu_decode and the result queue with byte serializer.
// A plain byte passes the input register and then the result queue before the output.
// Throughput: one input word per cycle; an entity that decodes to N bytes leaves the output
// as N words, and a two-group result queue absorbs those bursts. The input side stalls
// only while the input register waits on a full result queue.
// Reset (rst_ni low, asynchronous) clears the parse state, the input register and the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xml_entity_unescaper #(
  parameter int unsigned MAX_ENTITY_LEN = xeu_pkg::MAX_ENTITY_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] in_byte
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // [7:0] out_byte
  output logic                         m_axis_tlast_o,
  output logic [xeu_pkg::STATUS_W-1:0] m_axis_tuser_o   // [2:0] status
);
  import xeu_pkg::*;

  localparam int unsigned QD = 2;
  localparam logic [1:0] Q_FULL = 2'(QD);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;

  grp_t       grp;
  logic       grp_valid;

  grp_t       grp_q [QD];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] q_cnt_q, q_cnt_d;
  logic [1:0] idx_q;
  grp_t       head;
  logic       push, pop, word_out;

  assign advance         = in_vld_q && (q_cnt_q != Q_FULL);
  assign s_axis_tready_o = !in_vld_q || (q_cnt_q != Q_FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  xeu_decode #(
    .MAX_LEN(MAX_ENTITY_LEN)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .grp_valid_o(grp_valid),
    .grp_o      (grp)
  );

  assign head     = grp_q[rd_ptr_q];
  assign push     = grp_valid;
  assign word_out = m_axis_tvalid_o && m_axis_tready_i;
  assign pop      = word_out && (idx_q == head.nm1);

  always_comb begin
    q_cnt_d = q_cnt_q;
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + 2'd1;
    end else if (pop && !push) begin
      q_cnt_d = q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      q_cnt_q  <= '0;
      idx_q    <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        idx_q    <= '0;
      end else if (word_out) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      grp_q[wr_ptr_q] <= grp;
    end
  end

  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = head.bytes[idx_q];
  assign m_axis_tlast_o  = head.last && (idx_q == head.nm1);
  assign m_axis_tuser_o  = head.status;

  `XEU_ASSERT(a_queue_bound, q_cnt_q <= Q_FULL, "Result queue count exceeds its depth.")
  `XEU_ASSERT_IMP(a_err_word, m_axis_tvalid_o && m_axis_tuser_o != ST_OK,
    m_axis_tlast_o && m_axis_tdata_o == 8'h00, "Error word without last or with data.")
  `XEU_ASSERT_IMP(a_idx_range, m_axis_tvalid_o, idx_q <= head.nm1,
    "Serializer index ran past the group length.")

endmodule
